// ===== rtl/zla_pkg.sv =====
// Shared types and constants of the zone lifecycle allocator.
// Holds the command and result words, the operation, status and zone state codes.
// No dependencies.
package zla_pkg;

	// Number of zones tracked and the widths that follow from it
	localparam int ZONE_COUNT = 1024;
	localparam int ZONE_AW    = $clog2(ZONE_COUNT);
	localparam int COUNT_W    = $clog2(ZONE_COUNT + 1);

	// Fixed field widths of the command and result words
	localparam int OP_W      = 2;
	localparam int ZID_W     = 10;
	localparam int OFF_W     = 16;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 11;
	localparam int MAXACT_W  = 11;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACTIVE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CHUNKS     = CFG_IDX_W'(1);

	// Reset values of the configuration registers
	localparam logic [MAXACT_W-1:0] MAX_ACTIVE_RST = MAXACT_W'(14);
	localparam logic [OFF_W-1:0]    CHUNKS_RST     = OFF_W'(1024);

	typedef enum logic [OP_W-1:0] {
		OP_GET    = 2'd0,
		OP_RETURN = 2'd1,
		OP_FAILED = 2'd2,
		OP_EVICT  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EVICT = 2'd1,
		STAT_RETRY = 2'd2,
		STAT_ERROR = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ZS_FREE    = 2'd0,
		ZS_ACTIVE  = 2'd1,
		ZS_WRITING = 2'd2,
		ZS_FULL    = 2'd3
	} zst_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [ZID_W-1:0] zone_id;
		logic [OFF_W-1:0] chunk_pos;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [ZID_W-1:0]     zone_id_res;
		logic [OFF_W-1:0]     chunk_pos_res;
		logic [CNT_OUT_W-1:0] active_count;
		logic [CNT_OUT_W-1:0] free_count;
		logic [CNT_OUT_W-1:0] full_count;
	} res_t;

	// One entry of the per-zone table
	typedef struct packed {
		zst_t             st;
		logic [OFF_W-1:0] off;
	} tbl_entry_t;

endpackage

// ===== rtl/zla_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the zone table and both zone queues. No dependencies.
module zla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/zone_lifecycle_allocator_top.sv =====
// Top level of the zone lifecycle allocator.
// Depends on zla_pkg and zla_ram.
//
// Usage
//   Command channel: a word on cmd is taken at a rising edge where start is
//   high and busy is low. One command is in flight at a time; busy stays high
//   until its result has been issued.
//   Result channel: done is high for exactly one cycle while result holds the
//   status, the handed-out zone and offset, and the active, free and full
//   counts after the command. The receiver cannot stall; it must take it.
//   Configuration: cfg_ready is always high; a word on cfg_index / cfg_data is
//   written when cfg_valid is high. Write only while the block is idle.
// Sequence (from the accept edge to the done cycle)
//   get opening a free zone, return, failed write, evict: GF1 or CHK, then done
//   get taking a queued active zone: GA1 then GA2 (queue read, then table read)
//   get answering evict-needed or retry, or a zone out of range: done from idle
//   A new command can be taken in the cycle done is high. The registered reads
//   of the zone table and queue memories set these steps.
// Reset
//   After arst_n is released the zone table is cleared, one entry a cycle,
//   over all ZONE_COUNT (1024) entries with busy high. Configuration writes are
//   taken during that pass.
module zone_lifecycle_allocator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  zla_pkg::cmd_t                        cmd,
	output logic                                 busy,
	output logic                                 done,
	output zla_pkg::res_t                        result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [zla_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [zla_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam logic [zla_pkg::ZONE_AW-1:0] ZONE_LAST =
		zla_pkg::ZONE_AW'(zla_pkg::ZONE_COUNT - 1);
	localparam int TBL_W = $bits(zla_pkg::tbl_entry_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_GA1,
		S_GA2,
		S_GF1,
		S_CHK
	} state_t;

	state_t state_q;

	logic [zla_pkg::ZONE_AW-1:0]  clr_q;
	logic [zla_pkg::ZONE_AW-1:0]  free_head_q, free_tail_q;
	logic [zla_pkg::ZONE_AW-1:0]  active_head_q, active_tail_q;
	logic [zla_pkg::COUNT_W-1:0]  free_level_q, active_level_q, writer_q, full_q;
	logic                         free_wrapped_q;
	logic [zla_pkg::MAXACT_W-1:0] max_active_q;
	logic [zla_pkg::OFF_W-1:0]    chunks_q;

	zla_pkg::op_t                 op_q;
	logic [zla_pkg::ZONE_AW-1:0]  zid_q;
	logic [zla_pkg::OFF_W-1:0]    off_q;
	logic [zla_pkg::ZONE_AW-1:0]  z_q;
	zla_pkg::stat_t               status_q;
	logic [zla_pkg::ZONE_AW-1:0]  zres_q;
	logic [zla_pkg::OFF_W-1:0]    ores_q;
	logic                         done_q;

	// Memory ports
	logic                         tbl_we;
	logic [zla_pkg::ZONE_AW-1:0]  tbl_waddr, tbl_raddr;
	zla_pkg::tbl_entry_t          tbl_wdata;
	logic [TBL_W-1:0]             tbl_rdata;
	logic                         act_we;
	logic [zla_pkg::ZONE_AW-1:0]  act_rdata;
	logic                         frf_we;
	logic [zla_pkg::ZONE_AW-1:0]  frf_rdata;

	zla_pkg::tbl_entry_t          ent;
	zla_pkg::op_t                 cmd_op;
	logic                         zone_in_range;
	logic [zla_pkg::COUNT_W-1:0]  total_active;
	logic                         no_zone, no_room;
	logic [zla_pkg::OFF_W-1:0]    ret_n;
	logic                         ret_close;
	logic                         chk_ok;
	logic [zla_pkg::ZONE_AW-1:0]  free_z;

	function automatic logic [zla_pkg::ZONE_AW-1:0] next_slot(
		input logic [zla_pkg::ZONE_AW-1:0] p
	);
		return (p == ZONE_LAST) ? '0 : p + 1'b1;
	endfunction

	// Decode the command and the entry read back from the zone table
	assign ent           = tbl_rdata;
	assign cmd_op        = zla_pkg::op_t'(cmd.opcode);
	assign zone_in_range = 32'(cmd.zone_id) < 32'(zla_pkg::ZONE_COUNT);
	assign total_active  = active_level_q + writer_q;
	assign no_zone       = (total_active == '0) && (free_level_q == '0);
	assign no_room       = (active_level_q == '0) &&
	                       !((32'(total_active) < 32'(max_active_q)) && (free_level_q != '0));
	assign ret_n         = ent.off + 1'b1;
	assign ret_close     = (ret_n == chunks_q);

	// A free queue slot never written since reset still holds its own index
	assign free_z = (free_wrapped_q || (free_head_q < free_tail_q)) ? frf_rdata : free_head_q;

	// Check the zone's state and offset against the command
	always_comb begin
		case (op_q)
			zla_pkg::OP_RETURN: chk_ok = (ent.st == zla_pkg::ZS_WRITING) && (ent.off == off_q);
			zla_pkg::OP_FAILED: chk_ok = (ent.st == zla_pkg::ZS_WRITING) && (ent.off == off_q) &&
			                             (ent.off < chunks_q);
			zla_pkg::OP_EVICT:  chk_ok = (ent.st == zla_pkg::ZS_FULL);
			default:            chk_ok = 1'b0;
		endcase
	end

	// Drive the zone table write enable, address and data, and the read address
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = zid_q;
		tbl_wdata = '{st: zla_pkg::ZS_FREE, off: '0};
		tbl_raddr = (state_q == S_GA1) ? act_rdata : zla_pkg::ZONE_AW'(cmd.zone_id);
		case (state_q)
			S_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
			end
			S_GA2: begin
				tbl_we    = 1'b1;
				tbl_waddr = z_q;
				tbl_wdata = '{st: zla_pkg::ZS_WRITING, off: ent.off};
			end
			S_GF1: begin
				tbl_we    = 1'b1;
				tbl_waddr = free_z;
				tbl_wdata = '{st: zla_pkg::ZS_WRITING, off: '0};
			end
			S_CHK: begin
				tbl_we = chk_ok;
				case (op_q)
					zla_pkg::OP_RETURN: tbl_wdata = ret_close ?
					                    '{st: zla_pkg::ZS_FULL, off: '0} :
					                    '{st: zla_pkg::ZS_ACTIVE, off: ret_n};
					zla_pkg::OP_FAILED: tbl_wdata = '{st: zla_pkg::ZS_ACTIVE, off: ent.off};
					default:            tbl_wdata = '{st: zla_pkg::ZS_FREE, off: '0};
				endcase
			end
			default: tbl_we = 1'b0;
		endcase
	end

	// Push onto the active queue on a good return that stays open or a good failed write
	assign act_we = (state_q == S_CHK) && chk_ok &&
	                (((op_q == zla_pkg::OP_RETURN) && !ret_close) || (op_q == zla_pkg::OP_FAILED));
	// Push onto the free queue on a good evict
	assign frf_we = (state_q == S_CHK) && chk_ok && (op_q == zla_pkg::OP_EVICT);

	zla_ram #(.WIDTH(TBL_W), .DEPTH(zla_pkg::ZONE_COUNT)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	zla_ram #(.WIDTH(zla_pkg::ZONE_AW), .DEPTH(zla_pkg::ZONE_COUNT)) u_active_q (
		.clk   (clk),
		.we    (act_we),
		.waddr (active_tail_q),
		.wdata (zid_q),
		.raddr (active_head_q),
		.rdata (act_rdata)
	);

	zla_ram #(.WIDTH(zla_pkg::ZONE_AW), .DEPTH(zla_pkg::ZONE_COUNT)) u_free_q (
		.clk   (clk),
		.we    (frf_we),
		.waddr (free_tail_q),
		.wdata (zid_q),
		.raddr (free_head_q),
		.rdata (frf_rdata)
	);

	// Sequencer, queue pointers, counts and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			free_head_q    <= '0;
			free_tail_q    <= '0;
			active_head_q  <= '0;
			active_tail_q  <= '0;
			free_level_q   <= zla_pkg::COUNT_W'(zla_pkg::ZONE_COUNT);
			active_level_q <= '0;
			writer_q       <= '0;
			full_q         <= '0;
			free_wrapped_q <= 1'b0;
			max_active_q   <= zla_pkg::MAX_ACTIVE_RST;
			chunks_q       <= zla_pkg::CHUNKS_RST;
			op_q           <= zla_pkg::OP_GET;
			zid_q          <= '0;
			off_q          <= '0;
			z_q            <= '0;
			status_q       <= zla_pkg::STAT_OK;
			zres_q         <= '0;
			ores_q         <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// Take configuration words
			if (cfg_valid) begin
				case (cfg_index)
					zla_pkg::REG_MAX_ACTIVE: max_active_q <= cfg_data[zla_pkg::MAXACT_W-1:0];
					zla_pkg::REG_CHUNKS:     chunks_q     <= cfg_data[zla_pkg::OFF_W-1:0];
					default:                 ;
				endcase
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= next_slot(clr_q);
					if (clr_q == ZONE_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q   <= cmd_op;
						zid_q  <= zla_pkg::ZONE_AW'(cmd.zone_id);
						off_q  <= cmd.chunk_pos;
						zres_q <= '0;
						ores_q <= '0;
						if (cmd_op == zla_pkg::OP_GET) begin
							if (no_zone) begin
								status_q <= zla_pkg::STAT_EVICT;
								done_q   <= 1'b1;
							end else if (no_room) begin
								status_q <= zla_pkg::STAT_RETRY;
								done_q   <= 1'b1;
							end else if (active_level_q != '0) begin
								state_q <= S_GA1;
							end else begin
								state_q <= S_GF1;
							end
						end else if (!zone_in_range) begin
							status_q <= zla_pkg::STAT_ERROR;
							done_q   <= 1'b1;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_GA1: begin
					// Hold the queue head while its table entry is read
					z_q     <= act_rdata;
					state_q <= S_GA2;
				end
				S_GA2: begin
					active_head_q  <= next_slot(active_head_q);
					active_level_q <= active_level_q - 1'b1;
					writer_q       <= writer_q + 1'b1;
					status_q       <= zla_pkg::STAT_OK;
					zres_q         <= z_q;
					ores_q         <= ent.off;
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				S_GF1: begin
					// Open the free head and hand it out at once: the active
					// queue push and pop cancel, only its pointers advance
					free_head_q   <= next_slot(free_head_q);
					free_level_q  <= free_level_q - 1'b1;
					active_head_q <= next_slot(active_head_q);
					active_tail_q <= next_slot(active_tail_q);
					writer_q      <= writer_q + 1'b1;
					status_q      <= zla_pkg::STAT_OK;
					zres_q        <= free_z;
					ores_q        <= '0;
					done_q        <= 1'b1;
					state_q       <= S_IDLE;
				end
				S_CHK: begin
					status_q <= chk_ok ? zla_pkg::STAT_OK : zla_pkg::STAT_ERROR;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
					if (chk_ok) begin
						case (op_q)
							zla_pkg::OP_RETURN: begin
								writer_q <= writer_q - 1'b1;
								if (ret_close) begin
									full_q <= full_q + 1'b1;
								end else begin
									active_tail_q  <= next_slot(active_tail_q);
									active_level_q <= active_level_q + 1'b1;
								end
							end
							zla_pkg::OP_FAILED: begin
								writer_q       <= writer_q - 1'b1;
								active_tail_q  <= next_slot(active_tail_q);
								active_level_q <= active_level_q + 1'b1;
							end
							zla_pkg::OP_EVICT: begin
								full_q       <= full_q - 1'b1;
								free_tail_q  <= next_slot(free_tail_q);
								free_level_q <= free_level_q + 1'b1;
								if (free_tail_q == ZONE_LAST) begin
									free_wrapped_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Outputs
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign cfg_ready = 1'b1;

	assign result.status        = status_q;
	assign result.zone_id_res   = zla_pkg::ZID_W'(zres_q);
	assign result.chunk_pos_res = ores_q;
	assign result.active_count  = zla_pkg::CNT_OUT_W'(total_active);
	assign result.free_count    = zla_pkg::CNT_OUT_W'(free_level_q);
	assign result.full_count    = zla_pkg::CNT_OUT_W'(full_q);

	// Every zone sits in exactly one of free, active, being written or full
	a_zone_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(free_level_q) + 32'(active_level_q) + 32'(writer_q) + 32'(full_q)) ==
		32'(zla_pkg::ZONE_COUNT))
		else $error("zone counts do not add up to the number of zones");

	// A command that does not succeed leaves every count as it was
	a_fail_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != zla_pkg::STAT_OK)) |->
		($stable(free_level_q) && $stable(active_level_q) && $stable(writer_q) && $stable(full_q)))
		else $error("counts changed on a command that did not succeed");

	// A result is only issued once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe raised while a command is still in flight");

endmodule

// ===== sim/tb_zone_lifecycle_allocator_top.sv =====
// Self-checking bench for the zone lifecycle allocator top level.
// Drives command and register words; checks each result against a predictor of
// the zone tables or a directed row's fixed word. Depends on zla_pkg, allocator RTL.
`timescale 1ns / 1ps

module tb_zone_lifecycle_allocator_top;
	import zla_pkg::*;

	localparam int GAP_MAX         = 17;
	localparam int STALL_LIMIT     = 5000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int MAX_REPORTS     = 10;

	// One row of the directed part: a register word or a command word
	typedef struct {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		cmd_t                  word;
		logic                  fixed;
		res_t                  want;
	} step_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	cmd_t                  cmd       = '0;
	logic                  busy;
	logic                  done;
	res_t                  result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predicted block state
	logic [MAXACT_W-1:0] cfg_max_active;
	logic [OFF_W-1:0]    cfg_chunks;
	zst_t                zone_st [ZONE_COUNT];
	logic [OFF_W-1:0]    zone_off [ZONE_COUNT];
	int unsigned         free_q[$];
	int unsigned         active_q[$];
	int unsigned         writer_cnt;
	int unsigned         full_cnt;
	// Zones being written and full zones, for building well-formed words
	int unsigned         zone_writing[$];
	int unsigned         zone_full[$];

	res_t        pending_results[$];
	step_t       directed_steps[$];
	logic        hold_fixed = 1'b0;
	res_t        hold_want  = '0;
	int unsigned cmds_sent  = 0;
	int unsigned cmds_taken = 0;
	int unsigned regs_sent  = 0;
	int unsigned regs_taken = 0;
	int unsigned failures   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left = 0;
	int unsigned status_seen [4];

	zone_lifecycle_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Drop one zone from a tracking list
	function automatic void drop_zone(ref int unsigned q[$], input int unsigned z);
		foreach (q[i]) begin
			if (q[i] == z) begin
				q.delete(i);
				return;
			end
		end
	endfunction

	// Put the predictor in its post-reset state
	function automatic void reset_zone_model();
		cfg_max_active = MAX_ACTIVE_RST;
		cfg_chunks     = CHUNKS_RST;
		free_q.delete();
		active_q.delete();
		zone_writing.delete();
		zone_full.delete();
		for (int i = 0; i < ZONE_COUNT; i++) begin
			zone_st[i]  = ZS_FREE;
			zone_off[i] = '0;
			free_q.push_back(i);
		end
		writer_cnt = 0;
		full_cnt   = 0;
	endfunction

	// Advance the zone tables by one command word and return its result word
	function automatic res_t apply_zone_op(cmd_t c);
		res_t             r;
		int unsigned      z;
		logic [OFF_W-1:0] nxt;
		r = '0;
		z = 32'(c.zone_id);
		case (op_t'(c.opcode))
			OP_GET: begin
				if (active_q.size() == 0 && writer_cnt == 0 && free_q.size() == 0) begin
					r.status = STAT_EVICT;
				end else if (active_q.size() == 0 &&
						!(writer_cnt < 32'(cfg_max_active) && free_q.size() != 0)) begin
					r.status = STAT_RETRY;
				end else begin
					// open the head free zone when nothing is queued as active
					if (active_q.size() == 0) begin
						z = free_q.pop_front();
						zone_st[z]  = ZS_ACTIVE;
						zone_off[z] = '0;
						active_q.push_back(z);
					end
					z = active_q.pop_front();
					r.zone_id_res   = ZID_W'(z);
					r.chunk_pos_res = zone_off[z];
					zone_st[z] = ZS_WRITING;
					writer_cnt++;
					zone_writing.push_back(z);
				end
			end
			OP_RETURN: begin
				if (zone_st[z] != ZS_WRITING || zone_off[z] != c.chunk_pos) begin
					r.status = STAT_ERROR;
				end else begin
					nxt = zone_off[z] + OFF_W'(1);
					writer_cnt--;
					drop_zone(zone_writing, z);
					// close only on an exact match, so a lowered size lets it run on
					if (nxt == cfg_chunks) begin
						zone_st[z]  = ZS_FULL;
						zone_off[z] = '0;
						full_cnt++;
						zone_full.push_back(z);
					end else begin
						zone_off[z] = nxt;
						zone_st[z]  = ZS_ACTIVE;
						active_q.push_back(z);
					end
				end
			end
			OP_FAILED: begin
				if (zone_st[z] != ZS_WRITING || zone_off[z] != c.chunk_pos ||
						zone_off[z] >= cfg_chunks) begin
					r.status = STAT_ERROR;
				end else begin
					writer_cnt--;
					drop_zone(zone_writing, z);
					zone_st[z] = ZS_ACTIVE;
					active_q.push_back(z);
				end
			end
			default: begin
				if (zone_st[z] != ZS_FULL) begin
					r.status = STAT_ERROR;
				end else begin
					zone_st[z]  = ZS_FREE;
					zone_off[z] = '0;
					free_q.push_back(z);
					full_cnt--;
					drop_zone(zone_full, z);
				end
			end
		endcase
		r.active_count = CNT_OUT_W'(active_q.size() + writer_cnt);
		r.free_count   = CNT_OUT_W'(free_q.size());
		r.full_count   = CNT_OUT_W'(full_cnt);
		return r;
	endfunction

	// Build a random word: mostly well-formed use of the zones, some noise
	function automatic cmd_t pick_random_cmd();
		cmd_t        c;
		int unsigned r;
		int unsigned z;
		r = $urandom_range(0, 99);
		c.opcode    = OP_GET;
		c.zone_id   = ZID_W'($urandom);
		c.chunk_pos = OFF_W'($urandom);
		if (r < 10) begin
			c.opcode = OP_W'($urandom);
		end else if (r >= 40 && r < 80 && zone_writing.size() != 0) begin
			z = zone_writing[$urandom_range(0, zone_writing.size() - 1)];
			c.zone_id   = ZID_W'(z);
			c.chunk_pos = zone_off[z];
			if (r < 65) begin
				c.opcode = OP_RETURN;
			end else if (r < 74) begin
				c.opcode = OP_FAILED;
			end else begin
				// broken word: right zone, wrong offset
				c.opcode = ($urandom_range(0, 1) != 0) ? OP_RETURN : OP_FAILED;
				c.chunk_pos = zone_off[z] + OFF_W'($urandom_range(1, 65535));
			end
		end else if (r >= 80 && zone_full.size() != 0) begin
			z = zone_full[$urandom_range(0, zone_full.size() - 1)];
			c.opcode  = OP_EVICT;
			c.zone_id = ZID_W'(z);
		end
		return c;
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		step_t s;
		s = '{default: '0};
		s.is_reg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = CFG_DATA_W'(val);
		directed_steps.push_back(s);
	endfunction

	function automatic void add_cmd(op_t op, int unsigned z, int unsigned off);
		step_t s;
		s = '{default: '0};
		s.word.opcode    = op;
		s.word.zone_id   = ZID_W'(z);
		s.word.chunk_pos = OFF_W'(off);
		directed_steps.push_back(s);
	endfunction

	// Command row whose result is read straight off the zone rules
	function automatic void add_chk(op_t op, int unsigned z, int unsigned off, stat_t st,
			int unsigned zr, int unsigned orr, int unsigned act, int unsigned fre,
			int unsigned ful);
		add_cmd(op, z, off);
		directed_steps[$].fixed              = 1'b1;
		directed_steps[$].want.status        = st;
		directed_steps[$].want.zone_id_res   = ZID_W'(zr);
		directed_steps[$].want.chunk_pos_res = OFF_W'(orr);
		directed_steps[$].want.active_count  = CNT_OUT_W'(act);
		directed_steps[$].want.free_count    = CNT_OUT_W'(fre);
		directed_steps[$].want.full_count    = CNT_OUT_W'(ful);
	endfunction

	// Offer one command word after a random gap and hold it until taken
	task automatic issue_cmd(input cmd_t c, input logic fixed, input res_t want);
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, GAP_MAX);
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(4, 16);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hold_fixed = fixed;
		hold_want  = want;
		start <= 1'b1;
		cmd   <= c;
		cmds_sent++;
		wait (cmds_taken == cmds_sent);
	endtask

	// Write one register once every result is in and the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		regs_sent++;
		wait (regs_taken == regs_sent);
		cfg_valid <= 1'b0;
	endtask

	// Check results, predict accepted words, take register writes, watch for stalls
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					if (failures < MAX_REPORTS)
						$display("Unexpected result word: st=%0d zone=%0d off=%0d %s%0d %s%0d %s%0d",
							result.status, result.zone_id_res, result.chunk_pos_res,
							"act=", result.active_count, "free=", result.free_count,
							"full=", result.full_count);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status ||
							result.zone_id_res !== want.zone_id_res ||
							result.chunk_pos_res !== want.chunk_pos_res ||
							result.active_count !== want.active_count ||
							result.free_count !== want.free_count ||
							result.full_count !== want.full_count) begin
						if (failures < MAX_REPORTS) begin
							$display("Mismatch: expected st=%0d zone=%0d off=%0d act=%0d free=%0d full=%0d",
								want.status, want.zone_id_res, want.chunk_pos_res,
								want.active_count, want.free_count, want.full_count);
							$display("          got      st=%0d zone=%0d off=%0d act=%0d free=%0d full=%0d",
								result.status, result.zone_id_res, result.chunk_pos_res,
								result.active_count, result.free_count, result.full_count);
						end
						failures++;
					end
				end
			end
			if (start && !busy) begin
				want = apply_zone_op(cmd);
				if (hold_fixed)
					want = hold_want;
				pending_results.push_back(want);
				status_seen[want.status]++;
				cmds_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_ACTIVE)
					cfg_max_active = cfg_data[MAXACT_W-1:0];
				else if (cfg_index == REG_CHUNKS)
					cfg_chunks = cfg_data;
				regs_taken++;
			end
			// hold a count of cycles in which no word moves
			if (done || (start && !busy) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned      mx;
		int unsigned      ch;
		foreach (status_seen[i]) status_seen[i] = 0;
		reset_zone_model();

		// Limits set low (one active zone, two chunks a zone), then the queues walked by hand
		add_reg(REG_MAX_ACTIVE, 1);
		add_reg(REG_CHUNKS, 2);
		add_chk(OP_GET, 1023, 16'hFFFF, STAT_OK, 0, 0, 1, 1023, 0);
		add_chk(OP_GET, 0, 0, STAT_RETRY, 0, 0, 1, 1023, 0);
		add_chk(OP_RETURN, 0, 5, STAT_ERROR, 0, 0, 1, 1023, 0);
		add_chk(OP_EVICT, 0, 0, STAT_ERROR, 0, 0, 1, 1023, 0);
		add_chk(OP_RETURN, 1, 0, STAT_ERROR, 0, 0, 1, 1023, 0);
		add_cmd(OP_FAILED, 0, 0);
		add_cmd(OP_GET, 0, 0);
		add_cmd(OP_RETURN, 0, 0);
		add_cmd(OP_GET, 0, 0);
		add_cmd(OP_FAILED, 0, 1);
		add_cmd(OP_GET, 0, 0);
		add_cmd(OP_RETURN, 0, 1);
		add_cmd(OP_EVICT, 0, 0);
		add_chk(OP_EVICT, 0, 0, STAT_ERROR, 0, 0, 0, 1024, 0);
		// Limits at their highest, then a size lowered below a zone's offset
		add_reg(REG_MAX_ACTIVE, 1024);
		add_reg(REG_CHUNKS, 65535);
		add_cmd(OP_GET, 0, 0);
		add_cmd(OP_RETURN, 1, 0);
		add_cmd(OP_GET, 0, 0);
		add_cmd(OP_RETURN, 1, 1);
		add_reg(REG_CHUNKS, 1);
		add_cmd(OP_GET, 0, 0);
		add_chk(OP_FAILED, 1, 2, STAT_ERROR, 0, 0, 1, 1023, 0);
		add_cmd(OP_RETURN, 1, 2);
		add_chk(OP_FAILED, 1023, 16'hFFFF, STAT_ERROR, 0, 0, 1, 1023, 0);
		add_chk(OP_EVICT, 1023, 16'hFFFF, STAT_ERROR, 0, 0, 1, 1023, 0);
		add_reg(REG_CHUNKS, 4);
		add_cmd(OP_GET, 0, 0);
		add_cmd(OP_RETURN, 1, 3);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_reg)
				write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
			else
				issue_cmd(directed_steps[i].word, directed_steps[i].fixed,
					directed_steps[i].want);
		end

		// Random phases, each under its own pair of limits
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					mx = 1024;
					ch = 65535;
				end
				1: begin
					mx = 1;
					ch = 1;
				end
				2: begin
					mx = $urandom_range(1, 32);
					ch = $urandom_range(1, 6);
				end
				default: begin
					mx = $urandom_range(1, 1024);
					ch = $urandom_range(1, 12);
				end
			endcase
			write_reg(REG_MAX_ACTIVE, CFG_DATA_W'(mx));
			write_reg(REG_CHUNKS, CFG_DATA_W'(ch));
			repeat (ITEMS_PER_PHASE) issue_cmd(pick_random_cmd(), 1'b0, '0);
		end

		// Drain outstanding results, then allow a short settling tail
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands and %0d register writes: %0d ok, %0d evict-needed,",
			cmds_taken, regs_taken, status_seen[STAT_OK], status_seen[STAT_EVICT]);
		$display("%0d retry, %0d error; zones full at the end: %0d, being written: %0d",
			status_seen[STAT_RETRY], status_seen[STAT_ERROR], full_cnt, writer_cnt);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
